// ===== src/cdq_pkg.sv =====
// shared types and constants for the coalescing deferred update queue
package cdq_pkg;

  localparam int ITEM_W   = 12;
  localparam int STATUS_W = 11;
  localparam int OUTC_W   = 3;

  localparam logic                CMD_POST    = 1'b0;
  localparam logic                CMD_DRAIN   = 1'b1;
  localparam logic [STATUS_W-1:0] FREE_STATUS = STATUS_W'(1024);

  localparam logic [OUTC_W-1:0] OUT_APPENDED = 3'd0;
  localparam logic [OUTC_W-1:0] OUT_UPDATED  = 3'd1;
  localparam logic [OUTC_W-1:0] OUT_CHANGE   = 3'd2;
  localparam logic [OUTC_W-1:0] OUT_DELETE   = 3'd3;
  localparam logic [OUTC_W-1:0] OUT_NOTHING  = 3'd4;

  typedef struct packed {
    logic                command;
    logic [ITEM_W-1:0]   item_index;
    logic [STATUS_W-1:0] new_status;
  } in_item_t;

  typedef struct packed {
    logic [OUTC_W-1:0]   outcome;
    logic [ITEM_W-1:0]   item_index_out;
    logic [STATUS_W-1:0] status_out;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [ITEM_W-1:0]   item;
    logic [STATUS_W-1:0] status;
  } entry_t;

  // control towards the pending mark store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_val;
  } mark_ctl_t;

endpackage

// ===== src/cdq_mark_store.sv =====
// pending mark memory with its clearing pass after reset
module cdq_mark_store #(
  parameter int MAX_ITEMS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cdq_pkg::mark_ctl_t            ctl,
  input  logic [$clog2(MAX_ITEMS)-1:0]  rd_addr,
  input  logic [$clog2(MAX_ITEMS)-1:0]  wr_addr,
  output logic                          mark,
  output logic                          clearing
);
  import cdq_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  logic            marks [MAX_ITEMS];
  logic [AW-1:0]   clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MAX_ITEMS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      marks[clr_addr] <= 1'b0;
    end else if (ctl.wr_en) begin
      marks[wr_addr] <= ctl.wr_val;
    end
    if (ctl.rd_en) begin
      mark <= marks[rd_addr];
    end
  end

endmodule

// ===== src/cdq_entry_store.sv =====
// entry list memory, one write and one registered read port
module cdq_entry_store #(
  parameter int MAX_ITEMS = 4096
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_ITEMS)-1:0]  wr_addr,
  input  cdq_pkg::entry_t               wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_ITEMS)-1:0]  rd_addr,
  output cdq_pkg::entry_t               rd_data
);
  import cdq_pkg::*;

  entry_t entries [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= entries[rd_addr];
    end
  end

endmodule

// ===== src/cdq_seq.sv =====
// sequencer: command decode, list search with the shared compare, output register
module cdq_seq #(
  parameter int MAX_ITEMS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  cdq_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output cdq_pkg::out_item_t            out_data,
  output cdq_pkg::mark_ctl_t            mark_ctl,
  output logic [$clog2(MAX_ITEMS)-1:0]  mark_rd_addr,
  output logic [$clog2(MAX_ITEMS)-1:0]  mark_wr_addr,
  input  logic                          mark,
  input  logic                          clearing,
  output logic                          ent_wr_en,
  output logic [$clog2(MAX_ITEMS)-1:0]  ent_wr_addr,
  output cdq_pkg::entry_t               ent_wr_data,
  output logic                          ent_rd_en,
  output logic [$clog2(MAX_ITEMS)-1:0]  ent_rd_addr,
  input  cdq_pkg::entry_t               ent_rd_data
);
  import cdq_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = (CW > ITEM_W) ? CW : ITEM_W;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_MARK     = 8'b0000_0100,
    S_SRCH_RD  = 8'b0000_1000,
    S_SRCH_CMP = 8'b0001_0000,
    S_APPEND   = 8'b0010_0000,
    S_DRAIN    = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_t;

  state_t              state, state_next;
  logic [ITEM_W-1:0]   item, item_next;
  logic [STATUS_W-1:0] status, status_next;
  logic [CW-1:0]       head, head_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       ptr, ptr_next;
  out_item_t           res, res_next;
  logic                out_valid_next;
  out_item_t           out_data_next;

  logic [XW-1:0]       in_item_x;
  logic [XW-1:0]       item_x;
  logic [XW-1:0]       drain_item_x;
  logic [CW-1:0]       head_inc;
  logic                hit;

  assign in_item_x    = XW'(in_data.item_index);
  assign item_x       = XW'(item);
  assign drain_item_x = XW'(ent_rd_data.item);
  assign head_inc     = head + CW'(1);
  // the one compare unit, reused for every entry of the search
  assign hit          = (ent_rd_data.item == item);
  assign in_ready     = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    item_next      = item;
    status_next    = status;
    head_next      = head;
    count_next     = count;
    ptr_next       = ptr;
    res_next       = res;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    mark_ctl       = '0;
    mark_rd_addr   = in_item_x[AW-1:0];
    mark_wr_addr   = item_x[AW-1:0];
    ent_wr_en      = 1'b0;
    ent_wr_addr    = count[AW-1:0];
    ent_wr_data    = '{item: item, status: status};
    ent_rd_en      = 1'b0;
    ent_rd_addr    = ptr[AW-1:0];

    unique case (state)
      S_CLEAR: begin
        if (!clearing) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_next   = in_data.item_index;
          status_next = in_data.new_status;
          if (in_data.command == CMD_DRAIN) begin
            if (head < count) begin
              ent_rd_en   = 1'b1;
              ent_rd_addr = head[AW-1:0];
              state_next  = S_DRAIN;
            end else begin
              head_next  = '0;
              count_next = '0;
              res_next   = '{outcome: OUT_NOTHING, item_index_out: '0,
                             status_out: '0, last: 1'b0};
              state_next = S_EMIT;
            end
          end else if (in_item_x < XW'(MAX_ITEMS)) begin
            mark_ctl.rd_en = 1'b1;
            state_next     = S_MARK;
          end else begin
            res_next   = '{outcome: OUT_NOTHING, item_index_out: in_data.item_index,
                           status_out: '0, last: 1'b0};
            state_next = S_EMIT;
          end
        end
      end
      S_MARK: begin
        if (mark) begin
          ptr_next   = head;
          state_next = S_SRCH_RD;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_SRCH_RD: begin
        if (ptr < count) begin
          ent_rd_en  = 1'b1;
          state_next = S_SRCH_CMP;
        end else begin
          // mark set but no live entry: treat as not pending
          state_next = S_APPEND;
        end
      end
      S_SRCH_CMP: begin
        if (hit) begin
          ent_wr_en   = 1'b1;
          ent_wr_addr = ptr[AW-1:0];
          res_next    = '{outcome: OUT_UPDATED, item_index_out: item,
                          status_out: '0, last: 1'b0};
          state_next  = S_EMIT;
        end else begin
          ptr_next   = ptr + CW'(1);
          state_next = S_SRCH_RD;
        end
      end
      S_APPEND: begin
        if (count >= CW'(MAX_ITEMS)) begin
          res_next = '{outcome: OUT_NOTHING, item_index_out: item,
                       status_out: '0, last: 1'b0};
        end else begin
          ent_wr_en       = 1'b1;
          mark_ctl.wr_en  = 1'b1;
          mark_ctl.wr_val = 1'b1;
          count_next      = count + CW'(1);
          res_next        = '{outcome: OUT_APPENDED, item_index_out: item,
                              status_out: '0, last: 1'b0};
        end
        state_next = S_EMIT;
      end
      S_DRAIN: begin
        if (drain_item_x < XW'(MAX_ITEMS)) begin
          mark_ctl.wr_en = 1'b1;
          mark_wr_addr   = drain_item_x[AW-1:0];
        end
        res_next.outcome        = (ent_rd_data.status == FREE_STATUS) ? OUT_DELETE
                                                                      : OUT_CHANGE;
        res_next.item_index_out = ent_rd_data.item;
        res_next.status_out     = ent_rd_data.status;
        if (head_inc >= count) begin
          head_next     = '0;
          count_next    = '0;
          res_next.last = 1'b1;
        end else begin
          head_next     = head_inc;
          res_next.last = 1'b0;
        end
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    item     <= item_next;
    status   <= status_next;
    ptr      <= ptr_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

  a_head_le_count: assert property (@(posedge clk) disable iff (rst)
    head <= count) else $error("drain head passed the entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS)) else $error("entry count beyond list depth");

  a_search_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH_CMP) |-> (ptr < count))
    else $error("search compared an entry outside the live list");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before the result was formed");

endmodule

// ===== src/coalescing_deferred_update_queue.sv =====
// Coalescing deferred update queue, top level. Items are handled one at a
// time; the input is not ready while an item is in progress. A post of a
// pending item scans the live entries from the oldest up to and including
// the match, since the search reads the entry list one entry at a time
// through its single read port and one compare unit. After reset the
// pending marks are cleared in a pass over all MAX_ITEMS entries, and the
// input stays not ready until that pass is over. A finished result waits
// in an output register, so the next item can be taken while it is still
// held.
module coalescing_deferred_update_queue #(
  parameter int MAX_ITEMS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cdq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cdq_pkg::out_item_t out_data
);
  import cdq_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  mark_ctl_t     mark_ctl;
  logic [AW-1:0] mark_rd_addr;
  logic [AW-1:0] mark_wr_addr;
  logic          mark;
  logic          clearing;
  logic          ent_wr_en;
  logic [AW-1:0] ent_wr_addr;
  entry_t        ent_wr_data;
  logic          ent_rd_en;
  logic [AW-1:0] ent_rd_addr;
  entry_t        ent_rd_data;

  cdq_seq #(.MAX_ITEMS(MAX_ITEMS)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mark_ctl     (mark_ctl),
    .mark_rd_addr (mark_rd_addr),
    .mark_wr_addr (mark_wr_addr),
    .mark         (mark),
    .clearing     (clearing),
    .ent_wr_en    (ent_wr_en),
    .ent_wr_addr  (ent_wr_addr),
    .ent_wr_data  (ent_wr_data),
    .ent_rd_en    (ent_rd_en),
    .ent_rd_addr  (ent_rd_addr),
    .ent_rd_data  (ent_rd_data)
  );

  cdq_mark_store #(.MAX_ITEMS(MAX_ITEMS)) u_marks (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mark_ctl),
    .rd_addr  (mark_rd_addr),
    .wr_addr  (mark_wr_addr),
    .mark     (mark),
    .clearing (clearing)
  );

  cdq_entry_store #(.MAX_ITEMS(MAX_ITEMS)) u_entries (
    .clk     (clk),
    .wr_en   (ent_wr_en),
    .wr_addr (ent_wr_addr),
    .wr_data (ent_wr_data),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_data)
  );

endmodule

// ===== verif/cdq_checker.sv =====
// result checker for the coalescing deferred update queue
`timescale 1ns / 100ps

module cdq_checker #(
  parameter int MAX_ITEMS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  cdq_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  cdq_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 reports_due
);

  import cdq_pkg::*;

  logic        marked [MAX_ITEMS];
  entry_t      entries [MAX_ITEMS];
  int unsigned fill;
  int unsigned head;
  out_item_t   expected_reports [$];

  // applies one command to the shadow queue and returns the report it causes
  function automatic out_item_t apply_cmd(input in_item_t cmd);
    out_item_t rep;
    int unsigned i;
    rep = '0;
    if (cmd.command == CMD_DRAIN) begin
      if (head >= fill) begin
        head = 0;
        fill = 0;
        rep.outcome = OUT_NOTHING;
        return rep;
      end
      rep.item_index_out = entries[head].item;
      rep.status_out     = entries[head].status;
      rep.outcome        = (entries[head].status == FREE_STATUS) ? OUT_DELETE : OUT_CHANGE;
      marked[entries[head].item] = 1'b0;
      head++;
      if (head >= fill) begin
        head = 0;
        fill = 0;
        rep.last = 1'b1;
      end
      return rep;
    end
    rep.item_index_out = cmd.item_index;
    if (cmd.item_index >= MAX_ITEMS) begin
      rep.outcome = OUT_NOTHING;
      return rep;
    end
    if (marked[cmd.item_index]) begin
      for (i = head; i < fill; i++) begin
        if (entries[i].item == cmd.item_index) begin
          entries[i].status = cmd.new_status;
          rep.outcome = OUT_UPDATED;
          return rep;
        end
      end
    end
    if (fill >= MAX_ITEMS) begin
      rep.outcome = OUT_NOTHING;
      return rep;
    end
    entries[fill] = '{item: cmd.item_index, status: cmd.new_status};
    fill++;
    marked[cmd.item_index] = 1'b1;
    rep.outcome = OUT_APPENDED;
    return rep;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      for (int k = 0; k < MAX_ITEMS; k++) marked[k] = 1'b0;
      fill = 0;
      head = 0;
      expected_reports.delete();
      mismatches = 0;
    end else begin
      // results first, so a report can never match the command taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("result transfer with nothing expected: outcome %0d item %0d",
                 out_data.outcome, out_data.item_index_out);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("outcome", want.outcome, out_data.outcome);
          check_field("item_index_out", want.item_index_out, out_data.item_index_out);
          check_field("status_out", want.status_out, out_data.status_out);
          check_field("last", want.last, out_data.last);
        end
      end
      if (in_valid && in_ready) expected_reports.push_back(apply_cmd(in_data));
    end
    reports_due = expected_reports.size();
  end

endmodule

// ===== verif/coalescing_deferred_update_queue_test.sv =====
// stimulus and verdict for the coalescing deferred update queue
`timescale 1ns / 100ps

module coalescing_deferred_update_queue_test;

  import cdq_pkg::*;

  localparam int MAX_ITEMS    = 4096;
  localparam int RANDOM_ITEMS = 1650;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;

  int mismatches;
  int reports_due;
  int send_idle = 20;
  int recv_idle = 67;
  int sent      = 0;

  // rough mirror of the live list, only used to shape the stimulus
  logic            queued [MAX_ITEMS];
  logic [ITEM_W-1:0] live_q [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  coalescing_deferred_update_queue #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  cdq_checker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .reports_due(reports_due)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic issue(input logic cmd, input logic [ITEM_W-1:0] idx,
                       input logic [STATUS_W-1:0] st);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, item_index: idx, new_status: st};
    do @(posedge clk); while (!in_ready);
    sent++;
    if (cmd == CMD_POST) begin
      if (!queued[idx]) begin
        queued[idx] = 1'b1;
        live_q.push_back(idx);
      end
    end else if (live_q.size() != 0) begin
      queued[live_q.pop_front()] = 1'b0;
    end
  endtask

  task automatic drain_cmd();
    issue(CMD_DRAIN, ITEM_W'($urandom_range(4095)), STATUS_W'($urandom_range(2047)));
  endtask

  // hold the sender off until every transfer has produced its result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
  endtask

  function automatic logic [STATUS_W-1:0] pick_status();
    case ($urandom_range(9))
      0, 1:    return FREE_STATUS;
      2:       return STATUS_W'($urandom_range(2047, 1025));
      3:       return $urandom_range(1) ? STATUS_W'(0) : STATUS_W'(2047);
      default: return STATUS_W'($urandom_range(1023));
    endcase
  endfunction

  task automatic run_episode();
    logic [ITEM_W-1:0] pool [48];
    int pool_n;
    int posts;
    int roll;
    pool_n = ($urandom_range(9) == 0) ? $urandom_range(48, 20) : $urandom_range(12, 1);
    for (int k = 0; k < pool_n; k++) begin
      if ($urandom_range(19) == 0) pool[k] = $urandom_range(1) ? ITEM_W'(0) : ITEM_W'(4095);
      else pool[k] = ITEM_W'($urandom_range(4095));
    end
    posts = $urandom_range(2 * pool_n + 4, 1);
    for (int k = 0; k < posts; k++) begin
      roll = $urandom_range(99);
      if (roll < 20) drain_cmd();
      else if (roll < 25) issue(CMD_POST, ITEM_W'($urandom_range(4095)), pick_status());
      else issue(CMD_POST, pool[$urandom_range(pool_n - 1)], pick_status());
    end
    // mostly empty the list so the last flag and the reset of the list get exercised
    if ($urandom_range(3) != 0) begin
      while (live_q.size() != 0) drain_cmd();
      if ($urandom_range(9) < 3) drain_cmd();
    end
  endtask

  initial begin : stimulus
    int directed_n;
    int done_n;
    for (int k = 0; k < MAX_ITEMS; k++) queued[k] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty drain, field extremes, in-place updates at head and tail
    drain_cmd();
    issue(CMD_POST, 12'd0, 11'd0);
    issue(CMD_POST, 12'hFFF, 11'h7FF);
    issue(CMD_POST, 12'h555, FREE_STATUS);
    issue(CMD_POST, 12'hAAA, 11'h3FF);
    issue(CMD_POST, 12'd0, FREE_STATUS);
    issue(CMD_POST, 12'hFFF, 11'd5);
    issue(CMD_POST, 12'hAAA, 11'h2AA);
    repeat (4) drain_cmd();
    drain_cmd();
    // status above the free code is a plain change
    issue(CMD_POST, 12'd7, 11'd1025);
    drain_cmd();
    // a drained item is no longer pending, so a new post appends again
    issue(CMD_POST, 12'd9, 11'd3);
    issue(CMD_POST, 12'd10, 11'd4);
    drain_cmd();
    issue(CMD_POST, 12'd9, FREE_STATUS);
    issue(CMD_POST, 12'd10, 11'd6);
    drain_cmd();
    drain_cmd();
    directed_n = sent;
    settle();

    while (sent < directed_n + RANDOM_ITEMS) begin
      done_n = sent - directed_n;
      if (done_n < RANDOM_ITEMS / 3) begin
        send_idle = 20;
        recv_idle = 67;
      end else if (done_n < 2 * RANDOM_ITEMS / 3) begin
        send_idle = 67;
        recv_idle = 20;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if ($urandom_range(9) == 0) settle();
      run_episode();
    end

    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && reports_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
